FILE: rtl/multi_pipe_ring_fifo_table_assert.svh
// assertion macros for the multi pipe ring fifo table rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef MULTI_PIPE_RING_FIFO_TABLE_ASSERT_SVH
`define MULTI_PIPE_RING_FIFO_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define MPRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mprf assertion failed");
// condition must never be true out of reset
`define MPRF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("mprf forbidden condition seen");
`else
`define MPRF_ASSERT(lbl, prop)
`define MPRF_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: rtl/mprf_pkg.sv
// shared constants, types and helpers of the multi pipe ring fifo table
// no dependencies
package mprf_pkg;

  localparam int unsigned NUM_PIPES  = 8;
  localparam int unsigned BUF_DEPTH  = 256;
  localparam int unsigned RING_DEPTH = NUM_PIPES * BUF_DEPTH;

  localparam int unsigned SLOT_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned PTR_W   = $clog2(BUF_DEPTH);
  localparam int unsigned FILL_W  = $clog2(BUF_DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(RING_DEPTH);
  localparam int unsigned ID_W    = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned USERS_W = 8;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [USERS_W-1:0] USERS_MAX = '1;
  localparam logic [BYTE_W-1:0]  TAB_BYTE  = 8'h09;

  typedef enum logic [REQ_W-1:0] {
    REQ_OPEN      = 3'd0,
    REQ_WRITE     = 3'd1,
    REQ_READ      = 3'd2,
    REQ_CLOSE     = 3'd3,
    REQ_CLOSE_ALL = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_WOULD_BLOCK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_EXEC   = 2'd1,
    FSM_RDWAIT = 2'd2
  } fsm_e;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [USERS_W-1:0] users;
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [FILL_W-1:0]  fill;
  } slot_t;

  // lookup result of the slot table for the current id
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
    slot_t             entry;
  } lookup_t;

  // update command into the slot table
  typedef struct packed {
    logic              we;
    logic              clear_all;
    logic [SLOT_W-1:0] idx;
    slot_t             entry;
  } tbl_upd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    nxt = (ptr == PTR_W'(BUF_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    return nxt;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [SLOT_W-1:0] idx,
                                                  input logic [PTR_W-1:0]  ptr);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(idx) * ADDR_W'(BUF_DEPTH);
    return base + ADDR_W'(ptr);
  endfunction

endpackage

FILE: rtl/mprf_ring_mem.sv
// byte ring storage of all pipes: one write port, one registered read port
// depends on mprf_pkg
module mprf_ring_mem (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [mprf_pkg::ADDR_W-1:0]         waddr_i,
  input  logic [mprf_pkg::BYTE_W-1:0]         wdata_i,
  input  logic                                re_i,
  input  logic [mprf_pkg::ADDR_W-1:0]         raddr_i,
  output logic [mprf_pkg::BYTE_W-1:0]         rdata_o
);

  logic [mprf_pkg::BYTE_W-1:0] mem_q [mprf_pkg::RING_DEPTH];
  logic [mprf_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mprf_slot_table.sv
// pipe descriptor table: id match, free slot search and entry update
// depends on mprf_pkg
module mprf_slot_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mprf_pkg::ID_W-1:0]   id_i,
  input  mprf_pkg::tbl_upd_t          upd_i,
  output mprf_pkg::lookup_t           lookup_o
);

  mprf_pkg::slot_t slots_q [mprf_pkg::NUM_PIPES];

  // lowest matching slot and lowest free slot win
  always_comb begin
    lookup_o = '0;
    for (int k = mprf_pkg::NUM_PIPES - 1; k >= 0; k--) begin
      if (slots_q[k].valid && (slots_q[k].id == id_i)) begin
        lookup_o.hit     = 1'b1;
        lookup_o.hit_idx = mprf_pkg::SLOT_W'(k);
      end
      if (!slots_q[k].valid) begin
        lookup_o.free_ok  = 1'b1;
        lookup_o.free_idx = mprf_pkg::SLOT_W'(k);
      end
    end
    lookup_o.entry = slots_q[lookup_o.hit_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mprf_pkg::NUM_PIPES; k++) begin
        slots_q[k] <= '0;
      end
    end else if (upd_i.clear_all) begin
      for (int k = 0; k < mprf_pkg::NUM_PIPES; k++) begin
        slots_q[k].valid <= 1'b0;
      end
    end else if (upd_i.we) begin
      slots_q[upd_i.idx] <= upd_i.entry;
    end
  end

endmodule

FILE: rtl/multi_pipe_ring_fifo_table.sv
// multi pipe ring fifo table: an item is accepted when start_i is high and busy_o low;
// done_o strobes the result from the done register after the EXEC state; a read that
// takes a byte first waits in RDWAIT for the registered read port of the ring memory
// a new item can be accepted in the strobe cycle
// reset clears the slot table and control; ring bytes are not cleared, reads only
// reach bytes that were written before
module multi_pipe_ring_fifo_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [mprf_pkg::REQ_W-1:0]     req_type_i,
  input  logic [mprf_pkg::ID_W-1:0]      pipe_id_i,
  input  logic [mprf_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                           done_o,
  output logic [mprf_pkg::STAT_W-1:0]    status_o,
  output logic [mprf_pkg::BYTE_W-1:0]    read_byte_o,
  output logic [mprf_pkg::USERS_W-1:0]   user_count_o
);

`include "multi_pipe_ring_fifo_table_assert.svh"

  // control state
  mprf_pkg::fsm_e state_q, state_d;
  logic           done_q, done_d;

  // captured item
  logic [mprf_pkg::REQ_W-1:0]  req_q, req_d;
  logic [mprf_pkg::ID_W-1:0]   id_q, id_d;
  logic [mprf_pkg::BYTE_W-1:0] byte_q, byte_d;

  // result registers
  mprf_pkg::status_e            status_q, status_d;
  logic [mprf_pkg::BYTE_W-1:0]  rbyte_q, rbyte_d;
  logic [mprf_pkg::USERS_W-1:0] users_q, users_d;

  // table and memory hookup
  mprf_pkg::lookup_t           lk;
  mprf_pkg::tbl_upd_t          upd;
  logic                        ring_we;
  logic                        ring_re;
  logic [mprf_pkg::ADDR_W-1:0] ring_waddr;
  logic [mprf_pkg::ADDR_W-1:0] ring_raddr;
  logic [mprf_pkg::BYTE_W-1:0] ring_rdata;
  logic [mprf_pkg::USERS_W-1:0] close_users;

  mprf_slot_table u_slot_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .id_i     (id_q),
    .upd_i    (upd),
    .lookup_o (lk)
  );

  mprf_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (byte_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  assign ring_waddr  = mprf_pkg::ring_addr(lk.hit_idx, lk.entry.wr_ptr);
  assign ring_raddr  = mprf_pkg::ring_addr(lk.hit_idx, lk.entry.rd_ptr);
  // close decrements but never below zero
  assign close_users = (lk.entry.users != '0) ? lk.entry.users - mprf_pkg::USERS_W'(1)
                                               : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mprf_pkg::FSM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    byte_q   <= byte_d;
    status_q <= status_d;
    rbyte_q  <= rbyte_d;
    users_q  <= users_d;
  end

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    req_d    = req_q;
    id_d     = id_q;
    byte_d   = byte_q;
    status_d = status_q;
    rbyte_d  = rbyte_q;
    users_d  = users_q;
    upd      = '0;
    ring_we  = 1'b0;
    ring_re  = 1'b0;

    unique case (state_q)
      mprf_pkg::FSM_IDLE: begin
        if (start_i) begin
          req_d   = req_type_i;
          id_d    = pipe_id_i;
          byte_d  = data_byte_i;
          state_d = mprf_pkg::FSM_EXEC;
        end
      end

      mprf_pkg::FSM_EXEC: begin
        // default result: ok, zero byte, zero users, delivered next cycle
        status_d = mprf_pkg::ST_OK;
        rbyte_d  = '0;
        users_d  = '0;
        done_d   = 1'b1;
        state_d  = mprf_pkg::FSM_IDLE;

        unique case (mprf_pkg::req_e'(req_q))
          mprf_pkg::REQ_OPEN: begin
            if (lk.hit) begin
              upd.we    = 1'b1;
              upd.idx   = lk.hit_idx;
              upd.entry = lk.entry;
              if (lk.entry.users != mprf_pkg::USERS_MAX) begin
                upd.entry.users = lk.entry.users + mprf_pkg::USERS_W'(1);
              end
              users_d = upd.entry.users;
            end else if (lk.free_ok) begin
              // claim a fresh slot with cleared pointers
              upd.we          = 1'b1;
              upd.idx         = lk.free_idx;
              upd.entry       = '0;
              upd.entry.valid = 1'b1;
              upd.entry.id    = id_q;
              upd.entry.users = mprf_pkg::USERS_W'(1);
              users_d         = mprf_pkg::USERS_W'(1);
            end else begin
              status_d = mprf_pkg::ST_TABLE_FULL;
            end
          end

          mprf_pkg::REQ_WRITE: begin
            if (!lk.hit) begin
              status_d = mprf_pkg::ST_NOT_FOUND;
            end else begin
              users_d = lk.entry.users;
              if (lk.entry.fill == mprf_pkg::FILL_W'(mprf_pkg::BUF_DEPTH)) begin
                status_d = mprf_pkg::ST_WOULD_BLOCK;
              end else begin
                ring_we          = 1'b1;
                upd.we           = 1'b1;
                upd.idx          = lk.hit_idx;
                upd.entry        = lk.entry;
                upd.entry.wr_ptr = mprf_pkg::ptr_inc(lk.entry.wr_ptr);
                upd.entry.fill   = lk.entry.fill + mprf_pkg::FILL_W'(1);
              end
            end
          end

          mprf_pkg::REQ_READ: begin
            if (!lk.hit) begin
              status_d = mprf_pkg::ST_NOT_FOUND;
              rbyte_d  = mprf_pkg::TAB_BYTE;
            end else begin
              users_d = lk.entry.users;
              if (lk.entry.fill == '0) begin
                status_d = mprf_pkg::ST_WOULD_BLOCK;
              end else begin
                // byte comes out of the ring memory in the next cycle
                ring_re          = 1'b1;
                upd.we           = 1'b1;
                upd.idx          = lk.hit_idx;
                upd.entry        = lk.entry;
                upd.entry.rd_ptr = mprf_pkg::ptr_inc(lk.entry.rd_ptr);
                upd.entry.fill   = lk.entry.fill - mprf_pkg::FILL_W'(1);
                done_d           = 1'b0;
                state_d          = mprf_pkg::FSM_RDWAIT;
              end
            end
          end

          mprf_pkg::REQ_CLOSE: begin
            if (!lk.hit) begin
              status_d = mprf_pkg::ST_NOT_FOUND;
            end else begin
              // last user frees the slot
              upd.we          = 1'b1;
              upd.idx         = lk.hit_idx;
              upd.entry       = lk.entry;
              upd.entry.users = close_users;
              upd.entry.valid = (close_users != '0);
              users_d         = close_users;
            end
          end

          mprf_pkg::REQ_CLOSE_ALL: begin
            upd.clear_all = 1'b1;
          end

          default: begin
            // undefined request: no effect, all-zero result
          end
        endcase
      end

      mprf_pkg::FSM_RDWAIT: begin
        status_d = mprf_pkg::ST_OK;
        rbyte_d  = ring_rdata;
        done_d   = 1'b1;
        state_d  = mprf_pkg::FSM_IDLE;
      end

      default: begin
        state_d = mprf_pkg::FSM_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != mprf_pkg::FSM_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_byte_o  = rbyte_q;
  assign user_count_o = users_q;

  // accepted item is always worked on in the next cycle
  `MPRF_ASSERT(a_accept_exec, (start_i && !busy_o) |=> (state_q == mprf_pkg::FSM_EXEC))
  // a result strobe only follows a working cycle
  `MPRF_ASSERT(a_done_src, done_o |-> $past(state_q != mprf_pkg::FSM_IDLE))
  // a ring read always lands in the wait state
  `MPRF_ASSERT(a_read_wait, ring_re |=> (state_q == mprf_pkg::FSM_RDWAIT))
  // never pop an empty pipe or push a full one
  `MPRF_ASSERT_NEVER(a_rd_empty, ring_re && (lk.entry.fill == '0))
  `MPRF_ASSERT_NEVER(a_wr_full, ring_we && (lk.entry.fill == mprf_pkg::FILL_W'(mprf_pkg::BUF_DEPTH)))

endmodule

FILE: sim/multi_pipe_ring_fifo_table_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the multi pipe ring fifo table: directed table, then random traffic
// replies are checked against typed directed rows, else a behavioral pipe table copy kept here
// depends on mprf_pkg and multi_pipe_ring_fifo_table
module multi_pipe_ring_fifo_table_tb;

  // undefined request codes, the block answers them with an all-zero ok
  localparam logic [mprf_pkg::REQ_W-1:0] REQ_RSVD_LO = 3'd5;
  localparam logic [mprf_pkg::REQ_W-1:0] REQ_RSVD_MID = 3'd6;
  localparam logic [mprf_pkg::REQ_W-1:0] REQ_RSVD_HI = 3'd7;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned POOL_SIZE = 10;      // more ids than slots, so the table fills up
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct packed {
    mprf_pkg::status_e            status;
    logic [mprf_pkg::BYTE_W-1:0]  rbyte;
    logic [mprf_pkg::USERS_W-1:0] users;
  } reply_t;

  // one row of the directed table
  typedef struct {
    logic [mprf_pkg::REQ_W-1:0]  req;
    logic [mprf_pkg::ID_W-1:0]   id;
    logic [mprf_pkg::BYTE_W-1:0] data;
    bit                          typed;
    reply_t                      reply;
  } row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic [mprf_pkg::REQ_W-1:0]    req_type_i = '0;
  logic [mprf_pkg::ID_W-1:0]     pipe_id_i = '0;
  logic [mprf_pkg::BYTE_W-1:0]   data_byte_i = '0;
  logic                          busy_o;
  logic                          done_o;
  logic [mprf_pkg::STAT_W-1:0]   status_o;
  logic [mprf_pkg::BYTE_W-1:0]   read_byte_o;
  logic [mprf_pkg::USERS_W-1:0]  user_count_o;

  // typed expectation travels with the item, sampled at the accepting edge
  bit                            row_typed = 1'b0;
  reply_t                        row_reply = '0;

  // behavioral copy of the pipe table
  logic                          pipe_valid [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::ID_W-1:0]     pipe_key   [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::USERS_W-1:0]  pipe_users [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::PTR_W-1:0]    pipe_rd    [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::PTR_W-1:0]    pipe_wr    [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::FILL_W-1:0]   pipe_fill  [mprf_pkg::NUM_PIPES];
  logic [mprf_pkg::BYTE_W-1:0]   ring_bytes [mprf_pkg::RING_DEPTH];

  reply_t                        reply_q[$];      // replies still owed by the block
  row_t                          dir_rows[$];
  logic [mprf_pkg::ID_W-1:0]     id_pool [POOL_SIZE];
  int unsigned                   fail_cnt = 0;
  int unsigned                   items_sent = 0;
  int unsigned                   stall_cnt = 0;
  int unsigned                   idle_pct = 14;

  multi_pipe_ring_fifo_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .pipe_id_i    (pipe_id_i),
    .data_byte_i  (data_byte_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_byte_o  (read_byte_o),
    .user_count_o (user_count_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apply one request to the table copy and return the reply it earns
  function automatic reply_t predict_reply(input logic [mprf_pkg::REQ_W-1:0] req,
                                           input logic [mprf_pkg::ID_W-1:0] id,
                                           input logic [mprf_pkg::BYTE_W-1:0] data);
    reply_t r;
    int     hit;
    int     free_k;
    r = '{mprf_pkg::ST_OK, 8'd0, 8'd0};
    hit = -1;
    free_k = -1;
    // walk downward so the lowest matching and the lowest free slot win
    for (int k = mprf_pkg::NUM_PIPES - 1; k >= 0; k--) begin
      if (pipe_valid[k] && pipe_key[k] == id) hit = k;
      if (!pipe_valid[k]) free_k = k;
    end
    case (req)
      mprf_pkg::REQ_OPEN: begin
        if (hit < 0 && free_k < 0) begin
          r.status = mprf_pkg::ST_TABLE_FULL;
        end else begin
          if (hit < 0) begin
            // claiming a slot clears whatever a close all left behind
            hit = free_k;
            pipe_valid[hit] = 1'b1;
            pipe_key[hit] = id;
            pipe_users[hit] = '0;
            pipe_rd[hit] = '0;
            pipe_wr[hit] = '0;
            pipe_fill[hit] = '0;
          end
          // user count saturates instead of wrapping
          if (pipe_users[hit] != mprf_pkg::USERS_MAX) begin
            pipe_users[hit] = pipe_users[hit] + 1'b1;
          end
          r.users = pipe_users[hit];
        end
      end
      mprf_pkg::REQ_WRITE: begin
        if (hit < 0) begin
          r.status = mprf_pkg::ST_NOT_FOUND;
        end else begin
          r.users = pipe_users[hit];
          if (pipe_fill[hit] == mprf_pkg::FILL_W'(mprf_pkg::BUF_DEPTH)) begin
            r.status = mprf_pkg::ST_WOULD_BLOCK;
          end else begin
            ring_bytes[hit * mprf_pkg::BUF_DEPTH + pipe_wr[hit]] = data;
            pipe_wr[hit] = (pipe_wr[hit] == mprf_pkg::PTR_W'(mprf_pkg::BUF_DEPTH - 1)) ?
                           '0 : pipe_wr[hit] + 1'b1;
            pipe_fill[hit] = pipe_fill[hit] + 1'b1;
          end
        end
      end
      mprf_pkg::REQ_READ: begin
        if (hit < 0) begin
          // a read of an unknown pipe answers with a tab byte
          r.status = mprf_pkg::ST_NOT_FOUND;
          r.rbyte = mprf_pkg::TAB_BYTE;
        end else begin
          r.users = pipe_users[hit];
          if (pipe_fill[hit] == '0) begin
            r.status = mprf_pkg::ST_WOULD_BLOCK;
          end else begin
            r.rbyte = ring_bytes[hit * mprf_pkg::BUF_DEPTH + pipe_rd[hit]];
            pipe_rd[hit] = (pipe_rd[hit] == mprf_pkg::PTR_W'(mprf_pkg::BUF_DEPTH - 1)) ?
                           '0 : pipe_rd[hit] + 1'b1;
            pipe_fill[hit] = pipe_fill[hit] - 1'b1;
          end
        end
      end
      mprf_pkg::REQ_CLOSE: begin
        if (hit < 0) begin
          r.status = mprf_pkg::ST_NOT_FOUND;
        end else begin
          if (pipe_users[hit] != '0) pipe_users[hit] = pipe_users[hit] - 1'b1;
          // last user gone frees the slot
          if (pipe_users[hit] == '0) pipe_valid[hit] = 1'b0;
          r.users = pipe_users[hit];
        end
      end
      mprf_pkg::REQ_CLOSE_ALL: begin
        // only the valid flags drop, pointers stay until the slot is claimed again
        for (int k = 0; k < mprf_pkg::NUM_PIPES; k++) pipe_valid[k] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [mprf_pkg::REQ_W-1:0] req,
                                  input logic [mprf_pkg::ID_W-1:0] id,
                                  input logic [mprf_pkg::BYTE_W-1:0] data, input bit typed,
                                  input mprf_pkg::status_e st,
                                  input logic [mprf_pkg::BYTE_W-1:0] rb,
                                  input logic [mprf_pkg::USERS_W-1:0] users);
    row_t row;
    row.req = req;
    row.id = id;
    row.data = data;
    row.typed = typed;
    row.reply = '{st, rb, users};
    dir_rows.push_back(row);
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [mprf_pkg::REQ_W-1:0] req,
                           input logic [mprf_pkg::ID_W-1:0] id,
                           input logic [mprf_pkg::BYTE_W-1:0] data, input bit typed,
                           input reply_t reply);
    start_i <= 1'b1;
    req_type_i <= req;
    pipe_id_i <= id;
    data_byte_i <= data;
    row_typed <= typed;
    row_reply <= reply;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  // sender gap of random length, drawn after an item is taken
  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // random request checked against the predictor only
  task automatic issue(input logic [mprf_pkg::REQ_W-1:0] req,
                       input logic [mprf_pkg::ID_W-1:0] id,
                       input logic [mprf_pkg::BYTE_W-1:0] data);
    send_item(req, id, data, 1'b0, '0);
    maybe_idle();
  endtask

  function automatic logic [mprf_pkg::REQ_W-1:0] rand_req();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return mprf_pkg::REQ_OPEN;
    if (r < 45) return mprf_pkg::REQ_WRITE;
    if (r < 70) return mprf_pkg::REQ_READ;
    if (r < 85) return mprf_pkg::REQ_CLOSE;
    if (r < 89) return mprf_pkg::REQ_CLOSE_ALL;
    if (r < 93) return mprf_pkg::REQ_W'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
    return mprf_pkg::REQ_OPEN;
  endfunction

  // mostly ids from a small pool so that lookups hit, now and then a wild one
  function automatic logic [mprf_pkg::ID_W-1:0] rand_id();
    if ($urandom_range(9) == 0) return mprf_pkg::ID_W'($urandom);
    return id_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  // open, a burst of writes, reads that may run past empty, maybe a close
  task automatic run_session();
    logic [mprf_pkg::ID_W-1:0] sid;
    int unsigned               n;
    sid = id_pool[$urandom_range(POOL_SIZE - 1)];
    n = $urandom_range(12, 1);
    issue(mprf_pkg::REQ_OPEN, sid, mprf_pkg::BYTE_W'($urandom));
    repeat (n) issue(mprf_pkg::REQ_WRITE, sid, mprf_pkg::BYTE_W'($urandom));
    repeat ($urandom_range(n + 2, n)) issue(mprf_pkg::REQ_READ, sid, mprf_pkg::BYTE_W'($urandom));
    if ($urandom_range(1) == 1) issue(mprf_pkg::REQ_CLOSE, sid, mprf_pkg::BYTE_W'($urandom));
  endtask

  // drop start and wait until every owed reply is in
  task automatic drain();
    start_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  // reply checker and predictor feed; all samples are the values before the edge
  always @(posedge clk_i) begin : scoreboard
    reply_t want;
    reply_t pred;
    if (rst_ni) begin
      // a reply leaves before the item accepted in the same cycle is predicted
      if (done_o) begin
        if (reply_q.size() == 0) begin
          $error("reply strobe with no request outstanding");
          fail_cnt++;
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            fail_cnt++;
          end
          if (read_byte_o !== want.rbyte) begin
            $error("read_byte mismatch: expected %0d, actual %0d", want.rbyte, read_byte_o);
            fail_cnt++;
          end
          if (user_count_o !== want.users) begin
            $error("user_count mismatch: expected %0d, actual %0d", want.users, user_count_o);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_o) begin
        // table copy always advances; typed rows are checked against the typed value
        pred = predict_reply(req_type_i, pipe_id_i, data_byte_i);
        reply_q.push_back(row_typed ? row_reply : pred);
      end
    end
  end

  // watchdog: ends the run when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("multi_pipe_ring_fifo_table_tb failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    logic [mprf_pkg::ID_W-1:0] deep_id;
    int unsigned               quota [3];
    int unsigned               target;
    quota = '{130, 130, 60};
    for (int k = 0; k < mprf_pkg::NUM_PIPES; k++) begin
      pipe_valid[k] = 1'b0;
      pipe_key[k] = '0;
      pipe_users[k] = '0;
      pipe_rd[k] = '0;
      pipe_wr[k] = '0;
      pipe_fill[k] = '0;
    end
    for (int a = 0; a < mprf_pkg::RING_DEPTH; a++) ring_bytes[a] = '0;
    for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = mprf_pkg::ID_W'($urandom);

    // directed table: id and data extremes, every request kind, the corner cases
    add_row(mprf_pkg::REQ_READ, 16'h1234, 8'h00, 1'b1,
            mprf_pkg::ST_NOT_FOUND, mprf_pkg::TAB_BYTE, 8'd0);  // read, no pipe
    add_row(mprf_pkg::REQ_WRITE, 16'hffff, 8'hff, 1'b1, mprf_pkg::ST_NOT_FOUND, 8'h00, 8'd0);
    add_row(mprf_pkg::REQ_CLOSE, 16'h0000, 8'h00, 1'b1, mprf_pkg::ST_NOT_FOUND, 8'h00, 8'd0);
    add_row(mprf_pkg::REQ_OPEN, 16'h0000, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_OPEN, 16'hffff, 8'hff, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_READ, 16'hffff, 8'h00, 1'b1,
            mprf_pkg::ST_WOULD_BLOCK, 8'h00, 8'd1);  // empty pipe
    add_row(mprf_pkg::REQ_WRITE, 16'hffff, 8'hff, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_WRITE, 16'hffff, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_READ, 16'hffff, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'hff, 8'd1);
    add_row(mprf_pkg::REQ_READ, 16'hffff, 8'hff, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_OPEN, 16'hffff, 8'h00, 1'b1,
            mprf_pkg::ST_OK, 8'h00, 8'd2);  // second user
    add_row(mprf_pkg::REQ_CLOSE, 16'hffff, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    // undefined codes are ignored
    add_row(REQ_RSVD_LO, 16'haaaa, 8'h55, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd0);
    add_row(REQ_RSVD_MID, 16'h5555, 8'haa, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd0);
    add_row(REQ_RSVD_HI, 16'hffff, 8'hff, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd0);
    add_row(mprf_pkg::REQ_WRITE, 16'h0000, 8'ha5, 1'b0, mprf_pkg::ST_OK, 8'h00, 8'd0);
    // fill the remaining six slots, then one more open finds the table full
    for (int k = 1; k <= mprf_pkg::NUM_PIPES - 2; k++) begin
      add_row(mprf_pkg::REQ_OPEN, mprf_pkg::ID_W'(k), 8'h00, 1'b1,
              mprf_pkg::ST_OK, 8'h00, 8'd1);
    end
    add_row(mprf_pkg::REQ_OPEN, 16'h8000, 8'h00, 1'b1, mprf_pkg::ST_TABLE_FULL, 8'h00, 8'd0);
    add_row(mprf_pkg::REQ_CLOSE_ALL, 16'h1234, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd0);
    add_row(mprf_pkg::REQ_READ, 16'h0000, 8'h00, 1'b1,
            mprf_pkg::ST_NOT_FOUND, mprf_pkg::TAB_BYTE, 8'd0);
    // reclaimed slot starts empty even though a byte was left in it
    add_row(mprf_pkg::REQ_OPEN, 16'h0000, 8'h00, 1'b1, mprf_pkg::ST_OK, 8'h00, 8'd1);
    add_row(mprf_pkg::REQ_READ, 16'h0000, 8'h00, 1'b1, mprf_pkg::ST_WOULD_BLOCK, 8'h00, 8'd1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 14;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req, dir_rows[i].id, dir_rows[i].data, dir_rows[i].typed,
                dir_rows[i].reply);
      maybe_idle();
    end
    drain();

    // three random phases: light sender gaps, heavy sender gaps, back to back
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 14 : (p == 1) ? 74 : 0;
      if (p == 2) begin
        // fill one pipe past full and drain it past empty
        deep_id = mprf_pkg::ID_W'($urandom);
        issue(mprf_pkg::REQ_CLOSE_ALL, deep_id, mprf_pkg::BYTE_W'($urandom));
        issue(mprf_pkg::REQ_OPEN, deep_id, mprf_pkg::BYTE_W'($urandom));
        repeat (mprf_pkg::BUF_DEPTH + 1) begin
          issue(mprf_pkg::REQ_WRITE, deep_id, mprf_pkg::BYTE_W'($urandom));
        end
        repeat (mprf_pkg::BUF_DEPTH + 1) begin
          issue(mprf_pkg::REQ_READ, deep_id, mprf_pkg::BYTE_W'($urandom));
        end
        // push the user count into saturation, then step it back down
        repeat (mprf_pkg::USERS_MAX + 1) begin
          issue(mprf_pkg::REQ_OPEN, deep_id, mprf_pkg::BYTE_W'($urandom));
        end
        repeat (3) issue(mprf_pkg::REQ_CLOSE, deep_id, mprf_pkg::BYTE_W'($urandom));
        issue(mprf_pkg::REQ_CLOSE_ALL, mprf_pkg::ID_W'($urandom), mprf_pkg::BYTE_W'($urandom));
      end
      target = items_sent + quota[p];
      while (items_sent < target) begin
        if ($urandom_range(99) < 45) run_session();
        else issue(rand_req(), rand_id(), mprf_pkg::BYTE_W'($urandom));
      end
      // hold off until the block has answered everything
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("multi_pipe_ring_fifo_table_tb passed");
    end else begin
      $display("multi_pipe_ring_fifo_table_tb failed");
    end
    $finish;
  end

endmodule
